>>> src/dpt_pkg.sv
// Shared types and constants for the digital PLL tracker.
// No dependencies; imported by every module of the block.
package dpt_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 32;
	localparam int FREQ_W   = PHASE_W + 1;
	localparam int CFG_W    = 32;
	localparam int ERR_W    = 16;
	localparam int ERR_FRAC = 15;
	localparam int ROM_W    = 15;

	// serial multiplier: unsigned A times unsigned B magnitude, 2-bit digits of B
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 16;
	localparam int MUL_ACC_W = MUL_A_W + MUL_B_W;
	localparam int PROD_W    = MUL_ACC_W + 1;
	localparam int MUL_DIGITS = MUL_B_W / 2;
	localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
	localparam int TERM_W    = PROD_W - ERR_FRAC;

	localparam logic [CFG_W-1:0] CENTER_RST = 32'd21474836;
	localparam logic [CFG_W-1:0] PROP_RST   = 32'd26986075;
	localparam logic [CFG_W-1:0] INTG_RST   = 32'd42389;

	typedef enum logic [1:0] {
		REG_CENTER = 2'd0,
		REG_PROP   = 2'd1,
		REG_INTG   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b_mag;
		logic               neg;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

endpackage

>>> src/dpt_sine_rom.sv
// Quarter-wave sine ROM with quadrant folding, registered read.
// Depends on dpt_pkg; table is built at elaboration from a Q30 Taylor series.
module dpt_sine_rom #(
	parameter int SINE_INDEX_BITS = 10
) (
	input  logic                       clk,
	input  logic [dpt_pkg::PHASE_W-1:0] phase,
	output logic [dpt_pkg::ROM_W-1:0]  sine_mag,
	output logic                       sine_neg
);
	import dpt_pkg::*;

	localparam int QTR = 1 << SINE_INDEX_BITS;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [ROM_W-1:0] rom_t [0:QTR];

	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		for (int k = 0; k <= QTR; k++) begin
			x  = (64'(k) * HALF_PI_Q30) >> SINE_INDEX_BITS;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
			s  = (x * t) >> 30;
			v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			r[k] = v[ROM_W-1:0];
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [SINE_INDEX_BITS+1:0] top;
	logic [SINE_INDEX_BITS-1:0] k;
	logic [SINE_INDEX_BITS:0]   idx;
	logic [ROM_W-1:0]           rom_q;
	logic                       neg_q;

	assign top = phase[PHASE_W-1 -: SINE_INDEX_BITS+2];
	assign k   = top[SINE_INDEX_BITS-1:0];
	// odd quadrants read the table backwards
	assign idx = top[SINE_INDEX_BITS] ? ((SINE_INDEX_BITS+1)'(QTR) - {1'b0, k}) : {1'b0, k};

	always_ff @(posedge clk) begin
		rom_q <= ROM[idx];
		neg_q <= top[SINE_INDEX_BITS+1];
	end

	assign sine_mag = rom_q;
	assign sine_neg = neg_q;

endmodule

>>> src/dpt_serial_mult.sv
// Digit-serial multiplier, two bits of the B magnitude per cycle, sign applied last.
// Depends on dpt_pkg for widths and the request/response structs.
module dpt_serial_mult (
	input  logic              clk,
	input  logic              arst_n,
	input  dpt_pkg::mul_req_t req,
	output dpt_pkg::mul_rsp_t rsp
);
	import dpt_pkg::*;

	logic [MUL_ACC_W-1:0]     acc_q;
	logic [MUL_ACC_W-1:0]     a_q;
	logic [MUL_B_W-1:0]       b_q;
	logic                     neg_q;
	logic [MUL_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic                     fin_q;
	logic                     done_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [MUL_ACC_W-1:0]     pp;

	always_comb begin
		case (b_q[1:0])
			2'd0:    pp = '0;
			2'd1:    pp = a_q;
			2'd2:    pp = a_q << 1;
			default: pp = a_q + (a_q << 1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q && !busy_q && !req.start;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_DIGITS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= MUL_ACC_W'(req.a);
			b_q   <= req.b_mag;
			neg_q <= req.neg;
		end else if (busy_q) begin
			acc_q <= acc_q + pp;
			a_q   <= a_q << 2;
			b_q   <= b_q >> 2;
		end else if (fin_q) begin
			prod_q <= neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && !fin_q)
		else $error("multiplier started while busy");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> done_q)
		else $error("product not flagged after final digit");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q && !busy_q)
		else $error("done longer than one cycle");

endmodule

>>> src/digital_pll_tracker.sv
// Digital PLL tracker top level: sine lookup, phase detector, PI loop filter, NCO.
// Depends on dpt_pkg, dpt_sine_rom and dpt_serial_mult.
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall   | sample
//  out     | out_valid / out_stall | freq_word, phase_out, local_sine,
//          |                     |   detector_error, saturated
//  cfg     | cfg_we              | cfg_index, cfg_data
//
// Each item is accepted, then makes three passes through the shared serial multiplier
// (request, load, 8 two-bit digits, sign, handoff) and ends with the final sum step,
// which registers the result.
// Reset loads the default gains and center step, and clears phase and integrator.
// A result waits in the output register under out_stall; the next item is
// accepted and worked meanwhile, and holds in its last step until the register frees.
module digital_pll_tracker #(
	parameter int SINE_INDEX_BITS = 10,
	parameter int INTEG_BITS      = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [dpt_pkg::SAMPLE_W-1:0] sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dpt_pkg::FREQ_W-1:0]   freq_word,
	output logic [dpt_pkg::PHASE_W-1:0]         phase_out,
	output logic signed [dpt_pkg::ERR_W-1:0]    local_sine,
	output logic signed [dpt_pkg::ERR_W-1:0]    detector_error,
	output logic                               saturated,
	input  logic                               cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [dpt_pkg::CFG_W-1:0]           cfg_data
);
	import dpt_pkg::*;

	localparam int IW = INTEG_BITS;
	localparam int FW = INTEG_BITS + 2;

	typedef enum logic [2:0] {
		S_IDLE, S_E_GO, S_E_WAIT, S_I_GO, S_I_WAIT, S_P_GO, S_P_WAIT, S_FREQ
	} state_t;

	state_t                     state_q;
	logic [CFG_W-1:0]           center_q;
	logic [CFG_W-1:0]           prop_q;
	logic [CFG_W-1:0]           intg_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [ERR_W-1:0]    sine_q;
	logic signed [ERR_W-1:0]    err_q;
	logic signed [TERM_W-1:0]   pterm_q;
	logic signed [IW-1:0]       integ_q;
	logic [PHASE_W-1:0]         phase_q;
	logic                       sat_q;
	logic                       out_valid_q;
	mul_req_t                   mreq_q;
	mul_rsp_t                   mrsp;

	logic [ROM_W-1:0]           sine_mag;
	logic                       sine_neg;
	logic signed [ERR_W-1:0]    sine_val;
	logic [SAMPLE_W-1:0]        sample_mag;
	logic [ERR_W-1:0]           err_mag;
	logic signed [PROD_W-1:0]   err_sum;
	logic signed [TERM_W-1:0]   term;
	logic signed [IW:0]         isum;
	logic                       isat;
	logic signed [IW-1:0]       inext;
	logic signed [FW-1:0]       fsum;
	logic                       fsat;
	logic signed [FREQ_W-1:0]   fclip;
	logic                       out_free;

	dpt_sine_rom #(.SINE_INDEX_BITS(SINE_INDEX_BITS)) u_rom (
		.clk      (clk),
		.phase    (phase_q),
		.sine_mag (sine_mag),
		.sine_neg (sine_neg)
	);

	dpt_serial_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq_q),
		.rsp    (mrsp)
	);

	assign sine_val   = sine_neg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
	assign sample_mag = sample_q[SAMPLE_W-1] ? 16'(-sample_q) : 16'(sample_q);
	assign err_mag    = err_q[ERR_W-1] ? 16'(-err_q) : 16'(err_q);
	// round half up, then floor
	assign err_sum    = mrsp.prod + PROD_W'(1 << (ERR_FRAC - 1));
	assign term       = mrsp.prod[PROD_W-1:ERR_FRAC];

	assign isum  = {integ_q[IW-1], integ_q} + {{(IW+1-TERM_W){term[TERM_W-1]}}, term};
	assign isat  = isum[IW] != isum[IW-1];
	assign inext = isat ? (isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}})
	                    : isum[IW-1:0];

	assign fsum = $signed({{(FW-CFG_W){1'b0}}, center_q})
	            + {{(FW-TERM_W){pterm_q[TERM_W-1]}}, pterm_q}
	            + {{2{integ_q[IW-1]}}, integ_q};
	assign fsat  = fsum[FW-1:PHASE_W] != {(FW-PHASE_W){fsum[FW-1]}};
	assign fclip = fsat ? (fsum[FW-1] ? {1'b1, {PHASE_W{1'b0}}} : {1'b0, {PHASE_W{1'b1}}})
	                    : fsum[FREQ_W-1:0];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RST;
			prop_q   <= PROP_RST;
			intg_q   <= INTG_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_CENTER: center_q <= cfg_data;
				REG_PROP:   prop_q   <= cfg_data;
				REG_INTG:   intg_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			mreq_q.start <= 1'b0;
			phase_q      <= '0;
			integ_q      <= '0;
			sat_q        <= 1'b0;
		end else begin
			mreq_q.start <= (state_q == S_E_GO) || (state_q == S_I_GO) || (state_q == S_P_GO);
			// a load in S_FREQ takes priority over the clear
			if (out_valid_q && !out_stall && state_q != S_FREQ) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sample_q <= sample;
						state_q  <= S_E_GO;
					end
				end
				S_E_GO: begin
					sine_q       <= sine_val;
					sat_q        <= 1'b0;
					mreq_q.a     <= MUL_A_W'(sine_mag);
					mreq_q.b_mag <= sample_mag;
					mreq_q.neg   <= sample_q[SAMPLE_W-1] ^ sine_neg;
					state_q      <= S_E_WAIT;
				end
				S_E_WAIT: begin
					if (mrsp.done) begin
						err_q   <= err_sum[ERR_FRAC +: ERR_W];
						state_q <= S_I_GO;
					end
				end
				S_I_GO: begin
					mreq_q.a     <= intg_q;
					mreq_q.b_mag <= err_mag;
					mreq_q.neg   <= err_q[ERR_W-1];
					state_q      <= S_I_WAIT;
				end
				S_I_WAIT: begin
					if (mrsp.done) begin
						integ_q <= inext;
						sat_q   <= isat;
						state_q <= S_P_GO;
					end
				end
				S_P_GO: begin
					mreq_q.a     <= prop_q;
					mreq_q.b_mag <= err_mag;
					mreq_q.neg   <= err_q[ERR_W-1];
					state_q      <= S_P_WAIT;
				end
				S_P_WAIT: begin
					if (mrsp.done) begin
						pterm_q <= term;
						state_q <= S_FREQ;
					end
				end
				S_FREQ: begin
					if (out_free) begin
						phase_q        <= phase_q + fclip[PHASE_W-1:0];
						freq_word      <= fclip;
						phase_out      <= phase_q + fclip[PHASE_W-1:0];
						local_sine     <= sine_q;
						detector_error <= err_q;
						saturated      <= sat_q | fsat;
						out_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(freq_word) && $stable(phase_out)
			&& $stable(local_sine) && $stable(detector_error) && $stable(saturated))
		else $error("result changed while stalled");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while busy");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> state_q == S_IDLE)
		else $error("register written with an item in flight");

endmodule
